>>> src/cbq_pkg.sv
// shared types, constants and register codes for the cascaded biquad filter
`timescale 1ns / 1ps

package cbq_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_STAGES   = 8;
    localparam int DEF_SAMPLE_WIDTH = 24;

    // coefficient format, Q5.27
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 27;

    // configuration port
    localparam int                  CFG_INDEX_W       = 3;
    localparam int                  CFG_DATA_W        = 32;
    localparam int                  STAGE_COUNT_W     = 4;
    localparam logic [STAGE_COUNT_W-1:0] STAGE_COUNT_RESET = 4'd1;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COEF_A0     = 3'd0,
        CFG_COEF_A1     = 3'd1,
        CFG_COEF_A2     = 3'd2,
        CFG_COEF_B1     = 3'd3,
        CFG_COEF_B2     = 3'd4,
        CFG_STAGE_COUNT = 3'd5
    } t_cfg_reg;

    // item kinds after classification
    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_SAT,
        BK_DONE
    } t_back_state;

    // multiply-accumulate term within one stage
    typedef enum logic [2:0] {
        TERM_A0,
        TERM_A1,
        TERM_A2,
        TERM_B1,
        TERM_B2,
        TERM_LAST
    } t_term;

    // shared coefficient set
    typedef struct packed {
        logic signed [COEF_W-1:0] a0;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
    } t_coefs;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> src/cascaded_biquad_filter.sv
// top level of the cascaded biquad filter: config registers, front, queue and back
`timescale 1ns / 1ps
//
// Cascaded direct-form-I biquad filter, all stages sharing one coefficient set.
// Input channel: i_valid / o_stall carrying i_cmd and i_sample_in (Q1.23).
//   i_cmd low filters the sample, i_cmd high zeroes every stage delay and
//   produces no output beat.
// Output channel: o_valid / i_stall carrying o_sample_out, saturated Q1.23.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
//   indexes 0..4 are a0, a1, a2, b1, b2 (Q5.27), index 5 is the stage count.
//   Write only while the filter is idle.
// Processing: each stage runs its multiply-accumulate terms through one shared
//   33x24 multiplier, then one round/saturate step. A stage count of zero
//   gives the sample back unchanged.
// Queueing: the back end takes a new beat only while idle, one sample at a
//   time; a two-entry queue lets the input side keep accepting beats while a
//   sample is being filtered.
// Reset: coefficients zero, stage count one, all delays zero, no output valid.
// Stall: a held output keeps its beat in the output register; the back end
//   then waits and the queue fills, after which o_stall rises.
module cascaded_biquad_filter #(
    parameter int MAX_STAGES   = cbq_pkg::DEF_MAX_STAGES,
    parameter int SAMPLE_WIDTH = cbq_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        o_sample_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cbq_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [cbq_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import cbq_pkg::*;

    t_coefs                   r_coefs;
    logic [STAGE_COUNT_W-1:0] r_stage_count;
    logic                     cfg_we;

    logic                     w_push;
    logic                     w_pop;
    logic [SAMPLE_WIDTH:0]    w_item;
    logic [SAMPLE_WIDTH:0]    w_head;
    t_q_status                w_q_status;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs       <= '0;
            r_stage_count <= STAGE_COUNT_RESET;
        end else if (cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_COEF_A0:     r_coefs.a0    <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_A1:     r_coefs.a1    <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_A2:     r_coefs.a2    <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_B1:     r_coefs.b1    <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_B2:     r_coefs.b2    <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_STAGE_COUNT: r_stage_count <= i_cfg_data[STAGE_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input side
    cbq_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_sample_in (i_sample_in),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    // decoupling queue
    cbq_queue #(
        .WIDTH (SAMPLE_WIDTH + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // filter engine and output register
    cbq_back #(
        .MAX_STAGES   (MAX_STAGES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coefs       (r_coefs),
        .i_stage_count (r_stage_count),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample_out  (o_sample_out)
    );

    // queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("queue push while full");

    // queue never read while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("queue pop while empty");

    // no output beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

>>> src/cbq_queue.sv
// short fifo between the front classifier and the back sequencer
`timescale 1ns / 1ps

module cbq_queue #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_head,
    output cbq_pkg::t_q_status    o_status
);
    import cbq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    // pointer wrap at the depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

>>> src/cbq_front.sv
// input side: takes beats, classifies them and pushes them into the queue
`timescale 1ns / 1ps

module cbq_front #(
    parameter int SAMPLE_WIDTH = cbq_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  cbq_pkg::t_q_status             i_q_status,
    output logic                           o_push,
    output logic [SAMPLE_WIDTH:0]          o_item
);
    import cbq_pkg::*;

    t_op                     op;
    logic [SAMPLE_WIDTH-1:0] payload;

    // classify: a clear carries no sample
    always_comb begin
        op      = i_cmd ? OP_CLEAR : OP_FILTER;
        payload = (op == OP_CLEAR) ? '0 : i_sample_in;
    end

    // accept whenever the queue has room
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;
    assign o_item  = {op, payload};

endmodule

>>> src/cbq_back.sv
// back end: biquad stage sequencer with one shared multiplier and the delay lines
`timescale 1ns / 1ps

module cbq_back #(
    parameter int MAX_STAGES   = cbq_pkg::DEF_MAX_STAGES,
    parameter int SAMPLE_WIDTH = cbq_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  cbq_pkg::t_coefs                         i_coefs,
    input  logic [cbq_pkg::STAGE_COUNT_W-1:0]       i_stage_count,
    input  logic [SAMPLE_WIDTH:0]                   i_head,
    input  cbq_pkg::t_q_status                      i_q_status,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]          o_sample_out
);
    import cbq_pkg::*;

    localparam int IDX_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_STAGES + 1);
    localparam int OPC_W  = COEF_W + 1;
    localparam int PROD_W = SAMPLE_WIDTH + OPC_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] ROUND_INIT = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    t_back_state r_state;
    t_back_state n_state;
    t_term       r_term;

    logic [CNT_W-1:0] r_stage;
    logic [CNT_W-1:0] stage_next;
    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] idx;

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [SAMPLE_WIDTH-1:0] r_out;
    logic                           r_out_valid;

    logic signed [SAMPLE_WIDTH-1:0] r_xd1 [MAX_STAGES];
    logic signed [SAMPLE_WIDTH-1:0] r_xd2 [MAX_STAGES];
    logic signed [SAMPLE_WIDTH-1:0] r_yd1 [MAX_STAGES];
    logic signed [SAMPLE_WIDTH-1:0] r_yd2 [MAX_STAGES];

    t_op                            head_op;
    logic signed [SAMPLE_WIDTH-1:0] head_sample;
    logic signed [SAMPLE_WIDTH-1:0] op_x;
    logic signed [OPC_W-1:0]        op_c;
    logic signed [PROD_W-1:0]       mul_full;
    logic signed [ACC_W-1:0]        acc_shift;
    logic [ACC_W-SAMPLE_WIDTH:0]    acc_upper;
    logic signed [SAMPLE_WIDTH-1:0] sat_val;
    logic                           pop;
    logic                           load_out;

    // queue head fields
    assign head_op     = t_op'(i_head[SAMPLE_WIDTH]);
    assign head_sample = $signed(i_head[SAMPLE_WIDTH-1:0]);

    // active stage count, limited to the built stages
    always_comb begin
        if (int'(i_stage_count) > MAX_STAGES) begin
            n_eff = CNT_W'(MAX_STAGES);
        end else begin
            n_eff = CNT_W'(i_stage_count);
        end
    end

    assign idx        = r_stage[IDX_W-1:0];
    assign stage_next = r_stage + CNT_W'(1);

    // operand select for the shared multiplier, feedback terms negated
    always_comb begin
        unique case (r_term)
            TERM_A0: begin
                op_x = r_x;
                op_c = OPC_W'(i_coefs.a0);
            end
            TERM_A1: begin
                op_x = r_xd1[idx];
                op_c = OPC_W'(i_coefs.a1);
            end
            TERM_A2: begin
                op_x = r_xd2[idx];
                op_c = OPC_W'(i_coefs.a2);
            end
            TERM_B1: begin
                op_x = r_yd1[idx];
                op_c = -OPC_W'(i_coefs.b1);
            end
            TERM_B2: begin
                op_x = r_yd2[idx];
                op_c = -OPC_W'(i_coefs.b2);
            end
            default: begin
                op_x = '0;
                op_c = '0;
            end
        endcase
    end

    assign mul_full = op_x * op_c;

    // round already folded into the accumulator start, floor and saturate here
    always_comb begin
        acc_shift = r_acc >>> COEF_FRAC;
        acc_upper = acc_shift[ACC_W-1:SAMPLE_WIDTH-1];
        if ((&acc_upper) || !(|acc_upper)) begin
            sat_val = acc_shift[SAMPLE_WIDTH-1:0];
        end else if (r_acc[ACC_W-1]) begin
            sat_val = SAT_MIN;
        end else begin
            sat_val = SAT_MAX;
        end
    end

    // sequencer next state and controls
    always_comb begin
        n_state  = r_state;
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    pop = 1'b1;
                    if (head_op == OP_FILTER) begin
                        n_state = (n_eff == '0) ? BK_DONE : BK_MAC;
                    end
                end
            end
            BK_MAC: begin
                if (r_term == TERM_LAST) begin
                    n_state = BK_SAT;
                end
            end
            BK_SAT: begin
                n_state = (stage_next == n_eff) ? BK_DONE : BK_MAC;
            end
            BK_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // state and term counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_term  <= TERM_A0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_MAC && r_term != TERM_LAST) begin
                r_term <= t_term'(r_term + 3'd1);
            end else begin
                r_term <= TERM_A0;
            end
        end
    end

    // working sample, product, accumulator and stage index
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_x     <= head_sample;
                r_acc   <= ROUND_INIT;
                r_stage <= '0;
            end
            BK_MAC: begin
                if (r_term != TERM_LAST) begin
                    r_prod <= mul_full;
                end
                if (r_term != TERM_A0) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            BK_SAT: begin
                r_x     <= sat_val;
                r_acc   <= ROUND_INIT;
                r_stage <= stage_next;
            end
            default: begin
            end
        endcase
    end

    // per-stage delay lines, cleared at reset and by a clear beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_xd1[i] <= '0;
                r_xd2[i] <= '0;
                r_yd1[i] <= '0;
                r_yd2[i] <= '0;
            end
        end else if (pop && head_op == OP_CLEAR) begin
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_xd1[i] <= '0;
                r_xd2[i] <= '0;
                r_yd1[i] <= '0;
                r_yd2[i] <= '0;
            end
        end else if (r_state == BK_SAT) begin
            r_xd2[idx] <= r_xd1[idx];
            r_xd1[idx] <= r_x;
            r_yd2[idx] <= r_yd1[idx];
            r_yd1[idx] <= sat_val;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_x;
        end
    end

    assign o_pop        = pop;
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

endmodule

>>> tb/tb.sv
// self-checking testbench for the cascaded biquad filter
`timescale 1ns / 1ps

module tb;
    import cbq_pkg::*;

    localparam int SW          = DEF_SAMPLE_WIDTH;
    localparam int NSTAGE      = DEF_MAX_STAGES;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 150;
    localparam int CFG_UPPER_W = CFG_DATA_W - STAGE_COUNT_W - 4;

    // register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam logic signed [SW-1:0]     SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]     SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_ONE   = 32'sd1 <<< COEF_FRAC;

    typedef struct {
        t_op                 op;
        logic signed [SW-1:0] sample;
    } t_filter_beat;

    // dut signals
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_valid     = 1'b0;
    logic                        o_stall;
    logic                        i_cmd       = 1'b0;
    logic signed [SW-1:0]        i_sample_in = '0;
    logic                        o_valid;
    logic                        i_stall     = 1'b0;
    logic signed [SW-1:0]        o_sample_out;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_INDEX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data  = '0;

    // predicted filter state
    t_coefs                      coefs     = '0;
    logic [STAGE_COUNT_W-1:0]    stage_cfg = STAGE_COUNT_RESET;
    logic signed [SW-1:0]        x_hist1 [NSTAGE] = '{default: '0};
    logic signed [SW-1:0]        x_hist2 [NSTAGE] = '{default: '0};
    logic signed [SW-1:0]        y_hist1 [NSTAGE] = '{default: '0};
    logic signed [SW-1:0]        y_hist2 [NSTAGE] = '{default: '0};

    // stimulus, expected outputs and bookkeeping
    t_filter_beat                pending_beats[$];
    logic signed [SW-1:0]        expected_samples[$];
    int                          beats_queued   = 0;
    int                          beats_taken    = 0;
    int                          samples_sent   = 0;
    int                          clears_sent    = 0;
    int                          outputs_seen   = 0;
    int                          settings_used  = 0;
    int                          mismatch_count = 0;
    int                          cycle_count    = 0;
    int                          src_gap        = 0;
    int                          snk_run        = 0;
    logic                        snk_stalled    = 1'b0;
    logic                        no_idle        = 1'b0;

    cascaded_biquad_filter #(
        .MAX_STAGES  (NSTAGE),
        .SAMPLE_WIDTH(SW)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_sample_in (i_sample_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sample_out(o_sample_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // one direct-form-I stage: exact sum, round half up, saturate, shift delays
    function automatic logic signed [SW-1:0] biquad_step(int s, logic signed [SW-1:0] x);
        longint acc;
        longint sat_hi;
        longint sat_lo;
        sat_hi = longint'(SAMPLE_MAX);
        sat_lo = longint'(SAMPLE_MIN);
        acc = longint'(x) * longint'(coefs.a0)
            + longint'(x_hist1[s]) * longint'(coefs.a1)
            + longint'(x_hist2[s]) * longint'(coefs.a2)
            - longint'(y_hist1[s]) * longint'(coefs.b1)
            - longint'(y_hist2[s]) * longint'(coefs.b2)
            + (longint'(1) <<< (COEF_FRAC - 1));
        acc = acc >>> COEF_FRAC;
        if (acc > sat_hi) acc = sat_hi;
        if (acc < sat_lo) acc = sat_lo;
        x_hist2[s] = x_hist1[s];
        x_hist1[s] = x;
        y_hist2[s] = y_hist1[s];
        y_hist1[s] = acc[SW-1:0];
        return acc[SW-1:0];
    endfunction

    // predict the effect of one accepted input beat
    function automatic void apply_beat(t_op op, logic signed [SW-1:0] sample);
        int n;
        logic signed [SW-1:0] y;
        if (op == OP_CLEAR) begin
            for (int s = 0; s < NSTAGE; s++) begin
                x_hist1[s] = '0;
                x_hist2[s] = '0;
                y_hist1[s] = '0;
                y_hist2[s] = '0;
            end
            clears_sent++;
        end else begin
            n = (stage_cfg > NSTAGE) ? NSTAGE : int'(stage_cfg);
            y = sample;
            for (int s = 0; s < n; s++) y = biquad_step(s, y);
            expected_samples.push_back(y);
            samples_sent++;
        end
    endfunction

    task automatic report_mismatch(string what, logic signed [SW-1:0] want,
                                   logic signed [SW-1:0] got);
        $display("mismatch at cycle %0d: %s, expected %0d got %0d",
                 cycle_count, what, want, got);
        mismatch_count++;
    endtask

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // input driver: presents queued beats, holds them while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                apply_beat(t_op'(i_cmd), i_sample_in);
                beats_taken++;
                src_gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
            end
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                i_valid     <= 1'b1;
                i_cmd       <= pending_beats[0].op;
                i_sample_in <= pending_beats[0].sample;
                void'(pending_beats.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output monitor: checks each beat and makes stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                outputs_seen++;
                if (expected_samples.size() == 0) begin
                    report_mismatch("output beat with nothing pending", '0, o_sample_out);
                end else begin
                    if (o_sample_out !== expected_samples[0])
                        report_mismatch("sample_out", expected_samples[0], o_sample_out);
                    void'(expected_samples.pop_front());
                end
            end
            if (snk_run == 0) begin
                if (no_idle) begin
                    snk_stalled = 1'b0;
                    snk_run     = 16;
                end else begin
                    snk_stalled = ($urandom_range(0, 99) < 35);
                    snk_run     = snk_stalled ? idle_len() : $urandom_range(1, 20);
                end
            end
            snk_run--;
            i_stall <= snk_stalled;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one register write, updating the predicted configuration on the beat
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COEF_A0:     coefs.a0 = data;
            CFG_COEF_A1:     coefs.a1 = data;
            CFG_COEF_A2:     coefs.a2 = data;
            CFG_COEF_B1:     coefs.b1 = data;
            CFG_COEF_B2:     coefs.b2 = data;
            CFG_STAGE_COUNT: stage_cfg = data[STAGE_COUNT_W-1:0];
            default:         ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_coefs(logic [CFG_DATA_W-1:0] a0, logic [CFG_DATA_W-1:0] a1,
                              logic [CFG_DATA_W-1:0] a2, logic [CFG_DATA_W-1:0] b1,
                              logic [CFG_DATA_W-1:0] b2, logic [STAGE_COUNT_W-1:0] cnt);
        write_reg(CFG_COEF_A0, a0);
        write_reg(CFG_COEF_A1, a1);
        write_reg(CFG_COEF_A2, a2);
        write_reg(CFG_COEF_B1, b1);
        write_reg(CFG_COEF_B2, b2);
        // upper data bits are random so only the stage count field in the low bits matters
        write_reg(CFG_STAGE_COUNT,
                  {CFG_UPPER_W'($urandom_range(0, (1 << CFG_UPPER_W) - 1)),
                   4'b0000, cnt});
        settings_used++;
    endtask

    function automatic void queue_beat(t_op op, logic signed [SW-1:0] sample);
        t_filter_beat b;
        b.op     = op;
        b.sample = sample;
        pending_beats.push_back(b);
        beats_queued++;
    endfunction

    // wait until every beat is taken and answered, then let a trailing clear finish
    task automatic drain_phase();
        while (beats_taken != beats_queued) @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return $urandom;
        if (r < 90) return $urandom_range(0, 1 << (COEF_FRAC + 1)) - (1 << COEF_FRAC);
        if (r < 94) return COEF_MAX;
        if (r < 98) return COEF_MIN;
        return '0;
    endfunction

    function automatic logic [STAGE_COUNT_W-1:0] rand_stages();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return STAGE_COUNT_W'($urandom_range(1, 2));
        if (r < 70) return STAGE_COUNT_W'($urandom_range(3, NSTAGE - 1));
        if (r < 85) return STAGE_COUNT_W'(NSTAGE);
        if (r < 95) return '0;
        return STAGE_COUNT_W'($urandom_range(NSTAGE + 1, (1 << STAGE_COUNT_W) - 1));
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return SW'($urandom);
        if (r < 90) return SW'($urandom_range(0, 2048) - 1024);
        return (r < 95) ? SAMPLE_MAX : SAMPLE_MIN;
    endfunction

    // random phase: fresh settings, mostly samples with a few clears mixed in
    task automatic random_phase(int n_items);
        load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                   rand_stages());
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 8) queue_beat(OP_CLEAR, SW'($urandom));
            else queue_beat(OP_FILTER, rand_sample());
        end
        drain_phase();
    endtask

    // stimulus sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one stage with zero coefficients
        queue_beat(OP_FILTER, SAMPLE_MAX);
        queue_beat(OP_FILTER, SAMPLE_MIN);
        drain_phase();

        // zero stages pass the sample through; writes to spare indexes do nothing
        load_coefs(COEF_ONE, '0, '0, '0, '0, '0);
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, '1);
        queue_beat(OP_FILTER, SAMPLE_MAX);
        queue_beat(OP_FILTER, SAMPLE_MIN);
        queue_beat(OP_FILTER, '0);
        queue_beat(OP_FILTER, SW'(-1));
        drain_phase();

        // two stages with half-step rounding and a clear in the middle
        load_coefs(COEF_ONE >>> 1, COEF_ONE >>> 2, -(COEF_ONE >>> 2),
                   -(COEF_ONE >>> 1), COEF_ONE >>> 2, STAGE_COUNT_W'(2));
        queue_beat(OP_FILTER, SW'(1));
        queue_beat(OP_FILTER, SW'(-1));
        queue_beat(OP_FILTER, SAMPLE_MAX);
        queue_beat(OP_CLEAR, SAMPLE_MIN);
        queue_beat(OP_FILTER, SW'(1000));
        queue_beat(OP_FILTER, SW'(-1000));
        drain_phase();

        // largest coefficients through every stage: saturation both ways
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                   STAGE_COUNT_W'(NSTAGE));
        queue_beat(OP_FILTER, SAMPLE_MAX);
        queue_beat(OP_FILTER, SAMPLE_MIN);
        queue_beat(OP_FILTER, SAMPLE_MAX);
        drain_phase();

        // most negative coefficients and a stage count past the maximum
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, '1);
        queue_beat(OP_FILTER, SAMPLE_MIN);
        queue_beat(OP_FILTER, SAMPLE_MAX);
        queue_beat(OP_FILTER, SW'(1));
        queue_beat(OP_CLEAR, '0);
        queue_beat(OP_FILTER, SAMPLE_MIN);
        drain_phase();

        // random phases, two of them with no idling on either side
        for (int p = 0; p < 8; p++) begin
            no_idle = (p == 2 || p == 6);
            random_phase(48);
        end
        no_idle = 1'b0;

        // anything still pending at this point never came out
        while (expected_samples.size() != 0) begin
            report_mismatch("expected output never arrived", expected_samples[0], '0);
            void'(expected_samples.pop_front());
        end

        $display("covered %0d samples and %0d clears over %0d coefficient settings",
                 samples_sent, clears_sent, settings_used);
        $display("checked %0d output beats, %0d mismatches", outputs_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
